### sv/protobuf_wire_tokenizer_assert.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef PROTOBUF_WIRE_TOKENIZER_ASSERT_SVH
`define PROTOBUF_WIRE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PWT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwt assertion failed");

// Next-cycle implication, disabled while in reset.
`define PWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwt assertion failed");

`endif

### sv/pwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwt_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_KEY,
    PH_VARINT,
    PH_FIX64,
    PH_FIX32,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_VARINT,
    KIND_FIX64,
    KIND_FIX32,
    KIND_LEN_HDR,
    KIND_PAYLOAD,
    KIND_END_OK,
    KIND_ERROR
  } kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_VARINT_LONG,
    ERR_KEY_LARGE,
    ERR_FIELD_ZERO,
    ERR_WIRE_TYPE,
    ERR_TRUNCATED
  } err_t;

  // Wire types accepted in a key
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  // Byte counts
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [3:0] FIX64_BYTES      = 4'd8;
  localparam logic [3:0] FIX32_BYTES      = 4'd4;

  // A key must fit in this many bits
  localparam int KEY_BITS = 28;

  // Token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    kind_t        kind;
    logic [24:0]  field_number;
    logic [2:0]   wire_type;
    logic [63:0]  value;
    err_t         error_code;
  } token_t;

  // End-of-buffer report
  typedef struct packed {
    kind_t kind;
    err_t  error_code;
  } report_t;

  // One queue entry: everything one input byte produces
  typedef struct packed {
    logic    has_tok;
    token_t  tok;
    logic    has_rpt;
    report_t rpt;
  } entry_t;

endpackage

`default_nettype wire

### sv/protobuf_wire_tokenizer.sv
// Channel   Dir  tdata                                          tuser  tlast
// s_axis    in   [7:0] data_byte                                -      is_last
// m_axis    out  [24:0] field_number, [27:25] wire_type,        kind   last
//                [91:28] value, [94:92] error_code
// cfg       in   cfg_wdata = pass_payload, written when cfg_we is high
//
// One input byte is accepted per cycle while the token queue has room.
// A byte gives up to two results, sent one per cycle while m_axis_tready is high; input stalls only
// when the four-entry queue between parser and output register fills.
// An accepted byte's results pass through the token queue, then the output register.
// Reset is synchronous on rst; pass_payload comes back as 1.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_wire_tokenizer #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // field_number, wire_type, value, error_code
  output logic [2:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast
);

  logic            push;
  pwt_pkg::entry_t push_data;
  logic            pop;
  logic            full;
  logic            empty;
  pwt_pkg::entry_t head;
  pwt_pkg::token_t out_tok;

  pwt_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_full    (full),
    .in_ready  (s_axis_tready),
    .push      (push),
    .push_data (push_data)
  );

  pwt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  pwt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (out_tok),
    .out_last  (m_axis_tlast)
  );

  // Result packing, first field lowest
  assign m_axis_tuser = out_tok.kind;
  assign m_axis_tdata = {1'b0, out_tok.error_code, out_tok.value,
                         out_tok.wire_type, out_tok.field_number};

endmodule

`default_nettype wire

### sv/pwt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pwt_front #(
  parameter int LENGTH_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_data,
  input  wire logic              in_last,
  input  wire logic              q_full,
  output logic                   in_ready,
  output logic                   push,
  output pwt_pkg::entry_t        push_data
);

  // Parse state
  pwt_pkg::phase_t        phase, phase_next;
  logic [63:0]            acc, acc_next;
  logic [3:0]             cnt, cnt_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [24:0]            cur_field, cur_field_next;
  logic [2:0]             cur_wt, cur_wt_next;
  logic                   err_seen, err_seen_next;
  pwt_pkg::err_t          err_code, err_code_next;
  logic                   pass_payload;

  logic                   accept;
  logic [6:0]             vshamt;
  logic [5:0]             fshamt;
  logic [63:0]            vacc;
  logic [3:0]             cnt_inc;
  logic [3:0]             need;
  logic                   err_now;
  logic                   is_key;
  pwt_pkg::token_t        tok;
  logic                   tok_valid;
  pwt_pkg::report_t       rpt;
  logic                   rpt_valid;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Byte placement inside the accumulator
  assign vshamt  = 7'(cnt) * 7'd7;
  assign fshamt  = {cnt[2:0], 3'b000};
  assign vacc    = acc | (64'(in_data[6:0]) << vshamt);
  assign cnt_inc = cnt + 4'd1;
  assign need    = (phase == pwt_pkg::PH_FIX64) ? pwt_pkg::FIX64_BYTES : pwt_pkg::FIX32_BYTES;
  assign is_key  = (phase != pwt_pkg::PH_VARINT) && (phase != pwt_pkg::PH_LEN);

  // Byte classification and next state
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    remaining_next = remaining;
    cur_field_next = cur_field;
    cur_wt_next    = cur_wt;
    err_seen_next  = err_seen;
    err_code_next  = err_code;
    tok            = '0;
    tok_valid      = 1'b0;
    rpt            = '0;
    rpt_valid      = 1'b0;
    err_now        = 1'b0;

    if (!err_seen) begin
      unique case (phase) inside
        pwt_pkg::PH_FIX64, pwt_pkg::PH_FIX32: begin
          acc_next = acc | (64'(in_data) << fshamt);
          cnt_next = cnt_inc;
          if (cnt_inc >= need) begin
            tok_valid        = 1'b1;
            tok.kind         = (phase == pwt_pkg::PH_FIX64) ? pwt_pkg::KIND_FIX64
                                                             : pwt_pkg::KIND_FIX32;
            tok.field_number = cur_field;
            tok.wire_type    = cur_wt;
            tok.value        = acc_next;
            acc_next         = '0;
            cnt_next         = '0;
            phase_next       = pwt_pkg::PH_KEY;
          end
        end
        pwt_pkg::PH_PAYLOAD: begin
          if (pass_payload) begin
            tok_valid        = 1'b1;
            tok.kind         = pwt_pkg::KIND_PAYLOAD;
            tok.field_number = cur_field;
            tok.wire_type    = cur_wt;
            tok.value        = 64'(in_data);
          end
          if (remaining != '0) begin
            remaining_next = remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          end
          if (remaining_next == '0) begin
            phase_next = pwt_pkg::PH_KEY;
          end
        end
        default: begin
          // key, varint value and length varints
          if (is_key) begin
            phase_next = pwt_pkg::PH_KEY;
          end
          acc_next = vacc;
          if (in_data[7]) begin
            cnt_next = cnt_inc;
            if (cnt_inc >= pwt_pkg::VARINT_MAX_BYTES) begin
              err_now        = 1'b1;
              err_code_next  = pwt_pkg::ERR_VARINT_LONG;
            end
          end else begin
            acc_next = '0;
            cnt_next = '0;
            if (is_key) begin
              if (|vacc[63:pwt_pkg::KEY_BITS]) begin
                err_now       = 1'b1;
                err_code_next = pwt_pkg::ERR_KEY_LARGE;
              end else if (vacc[27:3] == '0) begin
                err_now       = 1'b1;
                err_code_next = pwt_pkg::ERR_FIELD_ZERO;
              end else if (vacc[2:0] != pwt_pkg::WT_VARINT && vacc[2:0] != pwt_pkg::WT_FIX64 &&
                           vacc[2:0] != pwt_pkg::WT_LEN && vacc[2:0] != pwt_pkg::WT_FIX32) begin
                err_now       = 1'b1;
                err_code_next = pwt_pkg::ERR_WIRE_TYPE;
              end else begin
                cur_field_next = vacc[27:3];
                cur_wt_next    = vacc[2:0];
                if (vacc[2:0] == pwt_pkg::WT_VARINT) begin
                  phase_next = pwt_pkg::PH_VARINT;
                end else if (vacc[2:0] == pwt_pkg::WT_FIX64) begin
                  phase_next = pwt_pkg::PH_FIX64;
                end else if (vacc[2:0] == pwt_pkg::WT_LEN) begin
                  phase_next = pwt_pkg::PH_LEN;
                end else begin
                  phase_next = pwt_pkg::PH_FIX32;
                end
              end
            end else if (phase == pwt_pkg::PH_VARINT) begin
              tok_valid        = 1'b1;
              tok.kind         = pwt_pkg::KIND_VARINT;
              tok.field_number = cur_field;
              tok.wire_type    = cur_wt;
              tok.value        = vacc;
              phase_next       = pwt_pkg::PH_KEY;
            end else begin
              if (|vacc[63:LENGTH_BITS]) begin
                // longer than any buffer can be
                err_now       = 1'b1;
                err_code_next = pwt_pkg::ERR_TRUNCATED;
              end else begin
                tok_valid        = 1'b1;
                tok.kind         = pwt_pkg::KIND_LEN_HDR;
                tok.field_number = cur_field;
                tok.wire_type    = cur_wt;
                tok.value        = vacc;
                if (vacc == '0) begin
                  phase_next = pwt_pkg::PH_KEY;
                end else begin
                  remaining_next = vacc[LENGTH_BITS-1:0];
                  phase_next     = pwt_pkg::PH_PAYLOAD;
                end
              end
            end
          end
          if (err_now) begin
            err_seen_next  = 1'b1;
            tok_valid      = 1'b1;
            tok.kind       = pwt_pkg::KIND_ERROR;
            tok.error_code = err_code_next;
          end
        end
      endcase
    end

    // Buffer end: report and start over
    if (in_last) begin
      if (!err_now) begin
        rpt_valid = 1'b1;
        if (err_seen) begin
          rpt.kind       = pwt_pkg::KIND_ERROR;
          rpt.error_code = err_code;
        end else if (phase_next != pwt_pkg::PH_KEY || cnt_next != '0) begin
          rpt.kind       = pwt_pkg::KIND_ERROR;
          rpt.error_code = pwt_pkg::ERR_TRUNCATED;
        end else begin
          rpt.kind       = pwt_pkg::KIND_END_OK;
          rpt.error_code = pwt_pkg::ERR_NONE;
        end
      end
      phase_next     = pwt_pkg::PH_KEY;
      acc_next       = '0;
      cnt_next       = '0;
      remaining_next = '0;
      cur_field_next = '0;
      cur_wt_next    = '0;
      err_seen_next  = 1'b0;
      err_code_next  = pwt_pkg::ERR_NONE;
    end
  end

  assign push      = accept && (tok_valid || rpt_valid);
  assign push_data = {tok_valid, tok, rpt_valid, rpt};

  // State and register update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pwt_pkg::PH_KEY;
      acc          <= '0;
      cnt          <= '0;
      remaining    <= '0;
      cur_field    <= '0;
      cur_wt       <= '0;
      err_seen     <= 1'b0;
      err_code     <= pwt_pkg::ERR_NONE;
      pass_payload <= 1'b1;
    end else begin
      if (cfg_we) begin
        pass_payload <= cfg_wdata;
      end
      if (accept) begin
        phase     <= phase_next;
        acc       <= acc_next;
        cnt       <= cnt_next;
        remaining <= remaining_next;
        cur_field <= cur_field_next;
        cur_wt    <= cur_wt_next;
        err_seen  <= err_seen_next;
        err_code  <= err_code_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/pwt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "protobuf_wire_tokenizer_assert.svh"

module pwt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pwt_pkg::entry_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output pwt_pkg::entry_t      head
);

  pwt_pkg::entry_t             mem [pwt_pkg::QUEUE_DEPTH];
  logic [pwt_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [pwt_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [pwt_pkg::QUEUE_AW:0]   count;

  assign full  = (count == (pwt_pkg::QUEUE_AW+1)'(pwt_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PWT_ASSERT_IMPLY(a_push_room, clk, rst, push, !full)
  `PWT_ASSERT_IMPLY(a_pop_data, clk, rst, pop, !empty)
  `PWT_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

`default_nettype wire

### sv/pwt_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "protobuf_wire_tokenizer_assert.svh"

module pwt_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire pwt_pkg::entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pwt_pkg::token_t      out_tok,
  output logic                 out_last
);

  logic            tok_done;
  logic            tok_done_next;
  logic            out_free;
  logic            send_tok;
  logic            load;
  logic            out_report;
  pwt_pkg::token_t rpt_tok;

  assign out_free = !out_valid || out_ready;
  assign load     = out_free && !empty;
  assign send_tok = head.has_tok && !tok_done;

  // End report widened to a full result
  always_comb begin
    rpt_tok            = '0;
    rpt_tok.kind       = head.rpt.kind;
    rpt_tok.error_code = head.rpt.error_code;
  end

  // Pop once every result of the head entry is loaded
  always_comb begin
    pop           = 1'b0;
    tok_done_next = tok_done;
    if (load) begin
      if (send_tok) begin
        pop           = !head.has_rpt;
        tok_done_next = head.has_rpt;
      end else begin
        pop           = 1'b1;
        tok_done_next = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tok_done  <= 1'b0;
    end else begin
      tok_done <= tok_done_next;
      if (out_free) begin
        out_valid <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_tok) begin
        out_tok  <= head.tok;
        out_last <= !head.has_rpt;
      end else begin
        out_tok  <= rpt_tok;
        out_last <= 1'b1;
      end
    end
  end

  // End or error result on the output
  assign out_report = (out_tok.kind == pwt_pkg::KIND_END_OK) ||
                      (out_tok.kind == pwt_pkg::KIND_ERROR);

  `PWT_ASSERT_IMPLY(a_split_head, clk, rst, tok_done, !empty && head.has_tok && head.has_rpt)
  `PWT_ASSERT_IMPLY(a_report_last, clk, rst, out_valid && out_report, out_last)
  `PWT_ASSERT_IMPLY(a_open_byte, clk, rst, out_valid && !out_last, tok_done)

endmodule

`default_nettype wire
